FILE: hw/rtl/hyl_pkg.sv
`timescale 1ns / 1ps
// hyl_pkg: widths, calendar constants, reciprocal constants and shared types
// for the hebrew year start and length unit. Depends on nothing.

package hyl_pkg;

	// field and internal widths
	localparam int YEAR_BITS  = 15;
	localparam int DAY_BITS   = 24;
	localparam int LEN_BITS   = 9;
	localparam int KIND_BITS  = 3;
	localparam int DIGIT_BITS = 4;
	localparam int CYC_BITS   = 5;
	localparam int WD_BITS    = 3;
	localparam int HR_BITS    = 5;
	localparam int MON_BITS   = YEAR_BITS + 4;
	localparam int HOUR_BITS  = MON_BITS + 4;
	localparam int DAYC_BITS  = MON_BITS + 5;
	localparam int PART_BITS  = 20;
	localparam int REM_BITS   = 11;
	localparam int DPART_BITS = 15;
	localparam int OFS_BITS   = 8;

	// pipeline stages in one year lane, front end excluded
	localparam int LANE_STAGES = 10;

	// calendar constants
	localparam int YEARS_PER_CYCLE  = 19;
	localparam int MONTHS_PER_CYCLE = 235;
	localparam int MONTHS_PER_YEAR  = 12;
	localparam int PARTS_PER_HOUR   = 1080;
	localparam int HOURS_PER_DAY    = 24;
	localparam int DAYS_PER_WEEK    = 7;
	localparam int MONTH_DAYS       = 29;
	localparam int MONTH_HOURS      = 12;
	localparam int MONTH_PARTS      = 793;
	localparam int EPOCH_HOURS      = 5;
	localparam int EPOCH_PARTS      = 204;
	localparam int CYC_LAST         = YEARS_PER_CYCLE - 1;
	localparam int LEN_COMMON_MAX   = 355;
	localparam int LEN_DIGIT_BASE   = 10;

	// postponement thresholds in parts of a day
	localparam logic [DPART_BITS-1:0] PARTS_NOON      = DPART_BITS'(19440);
	localparam logic [DPART_BITS-1:0] PARTS_TUE_LIMIT = DPART_BITS'(9924);
	localparam logic [DPART_BITS-1:0] PARTS_MON_LIMIT = DPART_BITS'(16789);

	// weekday codes of day count modulo seven
	localparam logic [WD_BITS-1:0] WD_SUN = 3'd0;
	localparam logic [WD_BITS-1:0] WD_MON = 3'd1;
	localparam logic [WD_BITS-1:0] WD_TUE = 3'd2;
	localparam logic [WD_BITS-1:0] WD_WED = 3'd3;
	localparam logic [WD_BITS-1:0] WD_FRI = 3'd5;
	localparam logic [WD_BITS-1:0] WD_SAT = 3'd6;

	// year kind codes before the leap offset
	localparam logic [KIND_BITS-1:0] KIND_DEFICIENT = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_REGULAR   = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_COMPLETE  = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_LEAP_OFS  = 3'd3;

	localparam logic [DIGIT_BITS-1:0] DIGIT_SHORT = 4'd3;
	localparam logic [DIGIT_BITS-1:0] DIGIT_LONG  = 4'd5;

	// reciprocal for division by 19 of a year number
	localparam int R19_SHIFT   = YEAR_BITS + 5;
	localparam int R19_BITS    = YEAR_BITS + 1;
	localparam int PROD19_BITS = 2 * YEAR_BITS + 1;
	localparam int Q19_BITS    = YEAR_BITS - 4;
	localparam logic [R19_BITS-1:0] R19_MUL =
		R19_BITS'(((64'd1 << R19_SHIFT) + 64'd18) / 64'd19);

	// reciprocal for division by 1080 of a month count
	localparam int RM_SHIFT   = MON_BITS + 11;
	localparam int RM_BITS    = MON_BITS + 1;
	localparam int PRODM_BITS = 2 * MON_BITS + 1;
	localparam int A_BITS     = MON_BITS - 10;
	localparam logic [RM_BITS-1:0] RM_MUL =
		RM_BITS'(((64'd1 << RM_SHIFT) + 64'd1079) / 64'd1080);

	// reciprocal for division by 1080 of the parts sum
	localparam int RP_SHIFT   = PART_BITS + 11;
	localparam int RP_BITS    = PART_BITS + 1;
	localparam int PRODP_BITS = 2 * PART_BITS + 1;
	localparam int PQ_BITS    = PART_BITS - 10;
	localparam logic [RP_BITS-1:0] RP_MUL =
		RP_BITS'(((64'd1 << RP_SHIFT) + 64'd1079) / 64'd1080);

	// reciprocal for division by 3 of hours over eight (hours / 24)
	localparam int H3_BITS    = HOUR_BITS - 3;
	localparam int R3_SHIFT   = H3_BITS + 2;
	localparam int R3_BITS    = H3_BITS + 1;
	localparam int PRODH_BITS = 2 * H3_BITS + 1;
	localparam int HD_BITS    = H3_BITS - 1;
	localparam logic [R3_BITS-1:0] R3_MUL =
		R3_BITS'(((64'd1 << R3_SHIFT) + 64'd2) / 64'd3);

	// reciprocal for division by 7 of a day count
	localparam int R7_SHIFT   = DAYC_BITS + 3;
	localparam int R7_BITS    = DAYC_BITS + 1;
	localparam int PRODD_BITS = 2 * DAYC_BITS + 1;
	localparam int Q7_BITS    = DAYC_BITS - 2;
	localparam logic [R7_BITS-1:0] R7_MUL =
		R7_BITS'(((64'd1 << R7_SHIFT) + 64'd6) / 64'd7);

	// reciprocal for division by 10 of a year length
	localparam int R10_SHIFT   = LEN_BITS + 4;
	localparam int R10_BITS    = LEN_BITS + 1;
	localparam int PRODL_BITS  = 2 * LEN_BITS + 1;
	localparam int Q10_BITS    = LEN_BITS - 3;
	localparam logic [R10_BITS-1:0] R10_MUL =
		R10_BITS'(((64'd1 << R10_SHIFT) + 64'd9) / 64'd10);

	// one year lane request: months before the year and its leap context
	typedef struct packed {
		logic [MON_BITS-1:0] months;
		logic                leap_this;
		logic                leap_prev;
	} lane_in_t;

	// leap context carried along a lane
	typedef struct packed {
		logic leap_this;
		logic leap_prev;
	} lane_flags_t;

	// per item side information that bypasses the lanes
	typedef struct packed {
		logic leap_year;
		logic year_ok;
	} side_t;

	// leap test on a year number modulo 19
	function automatic logic is_leap_res(input logic [CYC_BITS-1:0] res);
		logic leap;
		case (res) inside
			5'd0, 5'd3, 5'd6, 5'd8, 5'd11, 5'd14, 5'd17: leap = 1'b1;
			default: leap = 1'b0;
		endcase
		return leap;
	endfunction

	// months elapsed inside the current 19-year cycle
	function automatic logic [OFS_BITS-1:0] cycle_months(input logic [CYC_BITS-1:0] cyc);
		logic [OFS_BITS-1:0] extra;
		case (cyc) inside
			[5'd0:5'd2]:   extra = 8'd0;
			[5'd3:5'd5]:   extra = 8'd1;
			[5'd6:5'd7]:   extra = 8'd2;
			[5'd8:5'd10]:  extra = 8'd3;
			[5'd11:5'd13]: extra = 8'd4;
			[5'd14:5'd16]: extra = 8'd5;
			[5'd17:5'd18]: extra = 8'd6;
			default:       extra = 8'd0;
		endcase
		return (OFS_BITS'(cyc) * OFS_BITS'(MONTHS_PER_YEAR)) + extra;
	endfunction

endpackage

FILE: hw/rtl/hyl_front.sv
`timescale 1ns / 1ps
// hyl_front: three stage front end, year number to month counts of this and
// the next year plus leap context. Depends on hyl_pkg.

module hyl_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [hyl_pkg::YEAR_BITS-1:0]    year_number,
	output logic                             out_valid,
	output hyl_pkg::lane_in_t                lane_this,
	output hyl_pkg::lane_in_t                lane_next,
	output hyl_pkg::side_t                   side
);

	logic                               valid_s1, valid_s2, valid_s3;
	logic [hyl_pkg::YEAR_BITS-1:0]      prev_c;
	logic [hyl_pkg::YEAR_BITS-1:0]      prev_s1;
	logic [hyl_pkg::PROD19_BITS-1:0]    prod_s1;
	logic                               ok_s1, ok_s2;
	logic [hyl_pkg::Q19_BITS-1:0]       q_c, q_s2;
	logic [hyl_pkg::CYC_BITS-1:0]       cyc_c, cyc_s2;
	logic [hyl_pkg::CYC_BITS-1:0]       res_y_c, res_y1_c;
	logic                               leap_prev_c, leap_y_c, leap_y1_c;
	logic [hyl_pkg::MON_BITS-1:0]       months0_c, months1_c;
	hyl_pkg::lane_in_t                  lane_this_s3, lane_next_s3;
	hyl_pkg::side_t                     side_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: previous year times reciprocal of 19
	assign prev_c = year_number - hyl_pkg::YEAR_BITS'(1);

	always_ff @(posedge clk) begin
		prev_s1 <= prev_c;
		prod_s1 <= hyl_pkg::PROD19_BITS'(prev_c) * hyl_pkg::PROD19_BITS'(hyl_pkg::R19_MUL);
		ok_s1   <= (year_number != '0);
	end

	// stage 2: whole cycles and position in the cycle
	assign q_c   = prod_s1[hyl_pkg::R19_SHIFT +: hyl_pkg::Q19_BITS];
	assign cyc_c = hyl_pkg::CYC_BITS'(prev_s1 - hyl_pkg::YEAR_BITS'(q_c)
		* hyl_pkg::YEAR_BITS'(hyl_pkg::YEARS_PER_CYCLE));

	always_ff @(posedge clk) begin
		q_s2   <= q_c;
		cyc_s2 <= cyc_c;
		ok_s2  <= ok_s1;
	end

	// stage 3: month counts and leap context
	always_comb begin
		res_y_c  = (cyc_s2 == hyl_pkg::CYC_BITS'(hyl_pkg::CYC_LAST)) ? '0
			: cyc_s2 + hyl_pkg::CYC_BITS'(1);
		res_y1_c = (cyc_s2 >= hyl_pkg::CYC_BITS'(hyl_pkg::CYC_LAST - 1))
			? cyc_s2 - hyl_pkg::CYC_BITS'(hyl_pkg::CYC_LAST - 1)
			: cyc_s2 + hyl_pkg::CYC_BITS'(2);
		leap_prev_c = hyl_pkg::is_leap_res(cyc_s2);
		leap_y_c    = hyl_pkg::is_leap_res(res_y_c);
		leap_y1_c   = hyl_pkg::is_leap_res(res_y1_c);
		months0_c = hyl_pkg::MON_BITS'(q_s2) * hyl_pkg::MON_BITS'(hyl_pkg::MONTHS_PER_CYCLE)
			+ hyl_pkg::MON_BITS'(hyl_pkg::cycle_months(cyc_s2));
		months1_c = months0_c + hyl_pkg::MON_BITS'(hyl_pkg::MONTHS_PER_YEAR)
			+ hyl_pkg::MON_BITS'(leap_y_c);
	end

	always_ff @(posedge clk) begin
		lane_this_s3 <= '{months: months0_c, leap_this: leap_y_c, leap_prev: leap_prev_c};
		lane_next_s3 <= '{months: months1_c, leap_this: leap_y1_c, leap_prev: leap_y_c};
		side_s3      <= '{leap_year: leap_y_c, year_ok: ok_s2};
	end

	assign out_valid = valid_s3;
	assign lane_this = lane_this_s3;
	assign lane_next = lane_next_s3;
	assign side      = side_s3;

endmodule

FILE: hw/rtl/hyl_lane.sv
`timescale 1ns / 1ps
// hyl_lane: ten stage pipeline from a month count to the postponed new year
// day count. Depends on hyl_pkg.

module hyl_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  hyl_pkg::lane_in_t                 lane_in,
	output logic                              out_valid,
	output logic [hyl_pkg::DAYC_BITS-1:0]     day
);

	logic [hyl_pkg::LANE_STAGES-1:0]     valid_q;
	hyl_pkg::lane_flags_t                flags_s1, flags_s2, flags_s3, flags_s4, flags_s5;
	hyl_pkg::lane_flags_t                flags_s6, flags_s7, flags_s8, flags_s9;

	logic [hyl_pkg::MON_BITS-1:0]        months_s1, months_s2, months_s3, months_s4;
	logic [hyl_pkg::MON_BITS-1:0]        months_s5, months_s6;
	logic [hyl_pkg::PRODM_BITS-1:0]      prodm_s1;
	logic [hyl_pkg::A_BITS-1:0]          a_c, a_s2;
	logic [hyl_pkg::REM_BITS-1:0]        r_s2;
	logic [hyl_pkg::PART_BITS-1:0]       p_s3, p_s4;
	logic [hyl_pkg::HOUR_BITS-1:0]       hb_s3, hb_s4, h_s5, h_s6;
	logic [hyl_pkg::PRODP_BITS-1:0]      prodp_s4;
	logic [hyl_pkg::PQ_BITS-1:0]         pq_c;
	logic [hyl_pkg::REM_BITS-1:0]        pr_s5, pr_s6;
	logic [hyl_pkg::PRODH_BITS-1:0]      prodh_s6;
	logic [hyl_pkg::HD_BITS-1:0]         hd_c;
	logic [hyl_pkg::HR_BITS-1:0]         hr_c;
	logic [hyl_pkg::DPART_BITS-1:0]      parts_s7, parts_s8, parts_s9;
	logic [hyl_pkg::DAYC_BITS-1:0]       day0_s7, day0_s8, day0_s9, day_s10;
	logic [hyl_pkg::PRODD_BITS-1:0]      prodd_s8;
	logic [hyl_pkg::Q7_BITS-1:0]         q7_c;
	logic [hyl_pkg::WD_BITS-1:0]         wd_s9, wd1_c;
	logic                                postpone_c, bad_day_c;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[hyl_pkg::LANE_STAGES-2:0], in_valid};
		end
	end

	// stage 1: months times reciprocal of 1080
	always_ff @(posedge clk) begin
		months_s1 <= lane_in.months;
		flags_s1  <= '{leap_this: lane_in.leap_this, leap_prev: lane_in.leap_prev};
		prodm_s1  <= hyl_pkg::PRODM_BITS'(lane_in.months)
			* hyl_pkg::PRODM_BITS'(hyl_pkg::RM_MUL);
	end

	// stage 2: split months into thousands-eighty and remainder
	assign a_c = prodm_s1[hyl_pkg::RM_SHIFT +: hyl_pkg::A_BITS];

	always_ff @(posedge clk) begin
		a_s2      <= a_c;
		r_s2      <= hyl_pkg::REM_BITS'(months_s1 - hyl_pkg::MON_BITS'(a_c)
			* hyl_pkg::MON_BITS'(hyl_pkg::PARTS_PER_HOUR));
		months_s2 <= months_s1;
		flags_s2  <= flags_s1;
	end

	// stage 3: conjunction parts and hours before the carry
	always_ff @(posedge clk) begin
		p_s3      <= hyl_pkg::PART_BITS'(hyl_pkg::EPOCH_PARTS)
			+ hyl_pkg::PART_BITS'(r_s2) * hyl_pkg::PART_BITS'(hyl_pkg::MONTH_PARTS);
		hb_s3     <= hyl_pkg::HOUR_BITS'(hyl_pkg::EPOCH_HOURS)
			+ hyl_pkg::HOUR_BITS'(months_s2) * hyl_pkg::HOUR_BITS'(hyl_pkg::MONTH_HOURS)
			+ hyl_pkg::HOUR_BITS'(a_s2) * hyl_pkg::HOUR_BITS'(hyl_pkg::MONTH_PARTS);
		months_s3 <= months_s2;
		flags_s3  <= flags_s2;
	end

	// stage 4: parts times reciprocal of 1080
	always_ff @(posedge clk) begin
		prodp_s4  <= hyl_pkg::PRODP_BITS'(p_s3) * hyl_pkg::PRODP_BITS'(hyl_pkg::RP_MUL);
		p_s4      <= p_s3;
		hb_s4     <= hb_s3;
		months_s4 <= months_s3;
		flags_s4  <= flags_s3;
	end

	// stage 5: carry whole hours out of the parts
	assign pq_c = prodp_s4[hyl_pkg::RP_SHIFT +: hyl_pkg::PQ_BITS];

	always_ff @(posedge clk) begin
		pr_s5     <= hyl_pkg::REM_BITS'(p_s4 - hyl_pkg::PART_BITS'(pq_c)
			* hyl_pkg::PART_BITS'(hyl_pkg::PARTS_PER_HOUR));
		h_s5      <= hb_s4 + hyl_pkg::HOUR_BITS'(pq_c);
		months_s5 <= months_s4;
		flags_s5  <= flags_s4;
	end

	// stage 6: hours over eight times reciprocal of 3
	always_ff @(posedge clk) begin
		prodh_s6  <= hyl_pkg::PRODH_BITS'(h_s5[hyl_pkg::HOUR_BITS-1:3])
			* hyl_pkg::PRODH_BITS'(hyl_pkg::R3_MUL);
		h_s6      <= h_s5;
		pr_s6     <= pr_s5;
		months_s6 <= months_s5;
		flags_s6  <= flags_s5;
	end

	// stage 7: day count and parts of the day at the conjunction
	assign hd_c = prodh_s6[hyl_pkg::R3_SHIFT +: hyl_pkg::HD_BITS];
	assign hr_c = hyl_pkg::HR_BITS'(h_s6 - hyl_pkg::HOUR_BITS'(hd_c)
		* hyl_pkg::HOUR_BITS'(hyl_pkg::HOURS_PER_DAY));

	always_ff @(posedge clk) begin
		parts_s7 <= hyl_pkg::DPART_BITS'(pr_s6)
			+ hyl_pkg::DPART_BITS'(hr_c) * hyl_pkg::DPART_BITS'(hyl_pkg::PARTS_PER_HOUR);
		day0_s7  <= hyl_pkg::DAYC_BITS'(1)
			+ hyl_pkg::DAYC_BITS'(months_s6) * hyl_pkg::DAYC_BITS'(hyl_pkg::MONTH_DAYS)
			+ hyl_pkg::DAYC_BITS'(hd_c);
		flags_s7 <= flags_s6;
	end

	// stage 8: day count times reciprocal of 7
	always_ff @(posedge clk) begin
		prodd_s8 <= hyl_pkg::PRODD_BITS'(day0_s7) * hyl_pkg::PRODD_BITS'(hyl_pkg::R7_MUL);
		day0_s8  <= day0_s7;
		parts_s8 <= parts_s7;
		flags_s8 <= flags_s7;
	end

	// stage 9: weekday of the conjunction day
	assign q7_c = prodd_s8[hyl_pkg::R7_SHIFT +: hyl_pkg::Q7_BITS];

	always_ff @(posedge clk) begin
		wd_s9    <= hyl_pkg::WD_BITS'(day0_s8 - hyl_pkg::DAYC_BITS'(q7_c)
			* hyl_pkg::DAYC_BITS'(hyl_pkg::DAYS_PER_WEEK));
		day0_s9  <= day0_s8;
		parts_s9 <= parts_s8;
		flags_s9 <= flags_s8;
	end

	// stage 10: postponement rules
	always_comb begin
		postpone_c = (parts_s9 >= hyl_pkg::PARTS_NOON)
			|| (wd_s9 == hyl_pkg::WD_TUE && parts_s9 >= hyl_pkg::PARTS_TUE_LIMIT
				&& !flags_s9.leap_this)
			|| (wd_s9 == hyl_pkg::WD_MON && parts_s9 >= hyl_pkg::PARTS_MON_LIMIT
				&& flags_s9.leap_prev);
		if (!postpone_c) begin
			wd1_c = wd_s9;
		end else if (wd_s9 == hyl_pkg::WD_SAT) begin
			wd1_c = hyl_pkg::WD_SUN;
		end else begin
			wd1_c = wd_s9 + hyl_pkg::WD_BITS'(1);
		end
		case (wd1_c) inside
			hyl_pkg::WD_SUN, hyl_pkg::WD_WED, hyl_pkg::WD_FRI: bad_day_c = 1'b1;
			default: bad_day_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		day_s10 <= day0_s9 + hyl_pkg::DAYC_BITS'(postpone_c) + hyl_pkg::DAYC_BITS'(bad_day_c);
	end

	assign out_valid = valid_q[hyl_pkg::LANE_STAGES-1];
	assign day       = day_s10;

endmodule

FILE: hw/rtl/hyl_classify.sv
`timescale 1ns / 1ps
// hyl_classify: two stage back end, year length, kind and flags from two new
// year day counts, with output registers. Depends on hyl_pkg.

module hyl_classify (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [hyl_pkg::DAYC_BITS-1:0]     day_this,
	input  logic [hyl_pkg::DAYC_BITS-1:0]     day_next,
	input  hyl_pkg::side_t                    side_in,
	output logic                              out_valid,
	output logic [hyl_pkg::DAY_BITS-1:0]      year_start_days,
	output logic [hyl_pkg::LEN_BITS-1:0]      year_length,
	output logic [hyl_pkg::KIND_BITS-1:0]     year_kind,
	output logic                              leap_flag,
	output logic                              long_second_month,
	output logic                              short_third_month,
	output logic                              year_valid
);

	logic                                valid_s1, valid_s2;
	logic [hyl_pkg::LEN_BITS-1:0]        len_s1, len_s2;
	logic [hyl_pkg::DAY_BITS-1:0]        elapsed_s1, elapsed_s2;
	hyl_pkg::side_t                      side_s1;
	logic [hyl_pkg::PRODL_BITS-1:0]      prodl_c;
	logic [hyl_pkg::Q10_BITS-1:0]        q10_c;
	logic [hyl_pkg::DIGIT_BITS-1:0]      digit_c;
	logic [hyl_pkg::KIND_BITS-1:0]       kind_c, kind_s2;
	logic                                leap_s2, long_s2, short_s2, ok_s2;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: year length and the elapsed count
	always_ff @(posedge clk) begin
		len_s1     <= hyl_pkg::LEN_BITS'(day_next - day_this);
		elapsed_s1 <= hyl_pkg::DAY_BITS'(day_this);
		side_s1    <= side_in;
	end

	// stage 2: last decimal digit of the length and the year kind
	always_comb begin
		prodl_c = hyl_pkg::PRODL_BITS'(len_s1) * hyl_pkg::PRODL_BITS'(hyl_pkg::R10_MUL);
		q10_c   = prodl_c[hyl_pkg::R10_SHIFT +: hyl_pkg::Q10_BITS];
		digit_c = hyl_pkg::DIGIT_BITS'(len_s1 - hyl_pkg::LEN_BITS'(q10_c)
			* hyl_pkg::LEN_BITS'(hyl_pkg::LEN_DIGIT_BASE));
		if (digit_c <= hyl_pkg::DIGIT_SHORT) begin
			kind_c = hyl_pkg::KIND_DEFICIENT;
		end else if (digit_c >= hyl_pkg::DIGIT_LONG) begin
			kind_c = hyl_pkg::KIND_COMPLETE;
		end else begin
			kind_c = hyl_pkg::KIND_REGULAR;
		end
		if (len_s1 > hyl_pkg::LEN_BITS'(hyl_pkg::LEN_COMMON_MAX)) begin
			kind_c = kind_c + hyl_pkg::KIND_LEAP_OFS;
		end
	end

	// output registers, all fields cleared for an invalid year
	always_ff @(posedge clk) begin
		ok_s2 <= side_s1.year_ok;
		if (side_s1.year_ok) begin
			elapsed_s2 <= elapsed_s1;
			len_s2     <= len_s1;
			kind_s2    <= kind_c;
			leap_s2    <= side_s1.leap_year;
			long_s2    <= (digit_c == hyl_pkg::DIGIT_LONG);
			short_s2   <= (digit_c == hyl_pkg::DIGIT_SHORT);
		end else begin
			elapsed_s2 <= '0;
			len_s2     <= '0;
			kind_s2    <= '0;
			leap_s2    <= 1'b0;
			long_s2    <= 1'b0;
			short_s2   <= 1'b0;
		end
	end

	assign out_valid         = valid_s2;
	assign year_start_days   = elapsed_s2;
	assign year_length       = len_s2;
	assign year_kind         = kind_s2;
	assign leap_flag         = leap_s2;
	assign long_second_month = long_s2;
	assign short_third_month = short_s2;
	assign year_valid        = ok_s2;

endmodule

FILE: hw/rtl/hebrew_year_start_and_length_unit.sv
`timescale 1ns / 1ps
// hebrew_year_start_and_length_unit: top level, front end, one lane for this
// year and one for the next, side delay line and back end. Depends on hyl_pkg.
//
//  channel   direction  handshake            payload
//  command   in         start, busy          year_number
//  result    out        done (one cycle)     year_start_days, year_length, year_kind,
//                                            leap_flag, long_second_month,
//                                            short_third_month, year_valid
//
// One year is taken in every cycle; busy stays low, the pipeline never stops.
// Each command passes through 3 front stages (division by 19), 10 lane stages
// (reciprocal divisions by 1080, 1080, 24 and 7, postponement) and 2 back end
// stages. Reset clears the valid bits only; no results follow it until new
// commands arrive. Results come out in command order.

module hebrew_year_start_and_length_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [hyl_pkg::YEAR_BITS-1:0]     year_number,
	output logic                              done,
	output logic [hyl_pkg::DAY_BITS-1:0]      year_start_days,
	output logic [hyl_pkg::LEN_BITS-1:0]      year_length,
	output logic [hyl_pkg::KIND_BITS-1:0]     year_kind,
	output logic                              leap_flag,
	output logic                              long_second_month,
	output logic                              short_third_month,
	output logic                              year_valid
);

	logic                                front_valid;
	hyl_pkg::lane_in_t                   lane_this, lane_next;
	hyl_pkg::side_t                      front_side;
	hyl_pkg::side_t                      side_dly_q [hyl_pkg::LANE_STAGES];
	logic                                lane_valid;
	logic [hyl_pkg::DAYC_BITS-1:0]       day_this, day_next;

	// the pipeline never holds off a command
	assign busy = 1'b0;

	hyl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start),
		.year_number (year_number),
		.out_valid   (front_valid),
		.lane_this   (lane_this),
		.lane_next   (lane_next),
		.side        (front_side)
	);

	// new year of this year
	hyl_lane u_lane_this (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.lane_in   (lane_this),
		.out_valid (lane_valid),
		.day       (day_this)
	);

	// new year of the following year
	hyl_lane u_lane_next (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.lane_in   (lane_next),
		.out_valid (),
		.day       (day_next)
	);

	// side information kept level with the lanes
	always_ff @(posedge clk) begin
		side_dly_q[0] <= front_side;
		for (int i = 1; i < hyl_pkg::LANE_STAGES; i++) begin
			side_dly_q[i] <= side_dly_q[i-1];
		end
	end

	hyl_classify u_classify (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (lane_valid),
		.day_this          (day_this),
		.day_next          (day_next),
		.side_in           (side_dly_q[hyl_pkg::LANE_STAGES-1]),
		.out_valid         (done),
		.year_start_days   (year_start_days),
		.year_length       (year_length),
		.year_kind         (year_kind),
		.leap_flag         (leap_flag),
		.long_second_month (long_second_month),
		.short_third_month (short_third_month),
		.year_valid        (year_valid)
	);

endmodule
